// File: design/y422rgb_pkg.sv
// Shared types, codes and coefficients for the packed 4:2:2 to RGB converter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package y422rgb_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_SOURCE_ORDER  = 2'd0;
	localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 3;

	// Input byte orders.
	localparam logic [1:0] SRC_UYVY = 2'd0;
	localparam logic [1:0] SRC_YUYV = 2'd1;
	localparam logic [1:0] SRC_YVYU = 2'd2;

	// Output formats.
	localparam logic [2:0] FMT_UYVY = 3'd0;
	localparam logic [2:0] FMT_LUMA = 3'd1;
	localparam logic [2:0] FMT_RGB  = 3'd2;
	localparam logic [2:0] FMT_BGR  = 3'd3;
	localparam logic [2:0] FMT_RGBA = 3'd4;
	localparam logic [2:0] FMT_BGRA = 3'd5;

	// Byte counts of one result.
	localparam logic [2:0] CNT_LUMA = 3'd1;
	localparam logic [2:0] CNT_RGB  = 3'd3;
	localparam logic [2:0] CNT_FULL = 3'd4;

	// Fixed-point color matrix, scaled by 256.
	localparam logic signed [17:0] COEF_RV = 18'sd359;
	localparam logic signed [17:0] COEF_GU = 18'sd88;
	localparam logic signed [17:0] COEF_GV = 18'sd183;
	localparam logic signed [17:0] COEF_BU = 18'sd454;
	localparam logic [8:0]         CHROMA_OFS = 9'd128;
	localparam logic [7:0]         ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0]         CHAN_MAX = 8'd255;

	typedef struct packed {
		logic [7:0] byte_a;
		logic [7:0] byte_b;
		logic [7:0] byte_c;
		logic [7:0] byte_d;
		logic       frame_end;
	} mpix_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
		logic [7:0] out_d;
		logic [2:0] byte_count;
		logic       pair_last;
		logic       frame_last;
	} result_t;

	// One pixel (or one whole UYVY transaction) leaving the input stage.
	typedef struct packed {
		logic       vld;
		logic [7:0] y;
		logic [7:0] y_alt;
		logic [7:0] u;
		logic [7:0] v;
		logic [2:0] fmt;
		logic       pair_last;
		logic       frame_last;
	} issue_t;

	// Products of the color matrix.
	typedef struct packed {
		logic [7:0]  y;
		logic [7:0]  y_alt;
		logic [7:0]  u;
		logic [7:0]  v;
		logic [2:0]  fmt;
		logic        pair_last;
		logic        frame_last;
		logic [17:0] p_rv;
		logic [17:0] p_gu;
		logic [17:0] p_gv;
		logic [17:0] p_bu;
	} prod_t;

	// Channel sums before scaling and clamping.
	typedef struct packed {
		logic [7:0]  y;
		logic [7:0]  y_alt;
		logic [7:0]  u;
		logic [7:0]  v;
		logic [2:0]  fmt;
		logic        pair_last;
		logic        frame_last;
		logic [17:0] acc_r;
		logic [17:0] acc_g;
		logic [17:0] acc_b;
	} acc_t;

endpackage

`default_nettype wire

// File: design/y422rgb_unpack.sv
// Input stage: byte reordering, the stage-1 register and the pixel sequencer.
// Depends on y422rgb_pkg.
`default_nettype none

module y422rgb_unpack (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire y422rgb_pkg::mpix_t mpix,
	input  wire logic [1:0]         source_order,
	input  wire logic [2:0]         target_format,
	output logic                    busy,
	output y422rgb_pkg::issue_t     issue
);
	import y422rgb_pkg::*;

	logic [7:0] y0_in, y1_in, u_in, v_in;
	logic [2:0] fmt_in;

	logic       vld_s1;
	logic [7:0] y0_s1, y1_s1, u_s1, v_s1;
	logic       fe_s1;
	logic [2:0] fmt_s1;
	logic       phase_q;
	logic       two_px;

	always_comb begin
		unique case (source_order)
			SRC_YUYV: begin
				y0_in = mpix.byte_a; u_in = mpix.byte_b;
				y1_in = mpix.byte_c; v_in = mpix.byte_d;
			end
			SRC_YVYU: begin
				y0_in = mpix.byte_a; v_in = mpix.byte_b;
				y1_in = mpix.byte_c; u_in = mpix.byte_d;
			end
			default: begin
				u_in = mpix.byte_a; y0_in = mpix.byte_b;
				v_in = mpix.byte_c; y1_in = mpix.byte_d;
			end
		endcase
		// Undefined format codes behave as RGBA.
		fmt_in = (target_format > FMT_BGRA) ? FMT_RGBA : target_format;
	end

	// A pixel format holds the stage after Y0 to send pixel Y1.
	assign two_px = (fmt_s1 != FMT_UYVY);
	assign busy   = vld_s1 && two_px && !phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			vld_s1  <= accept || busy;
			phase_q <= busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y0_s1  <= y0_in;
			y1_s1  <= y1_in;
			u_s1   <= u_in;
			v_s1   <= v_in;
			fe_s1  <= mpix.frame_end;
			fmt_s1 <= fmt_in;
		end
	end

	always_comb begin
		issue.vld        = vld_s1;
		issue.y          = phase_q ? y1_s1 : y0_s1;
		issue.y_alt      = y1_s1;
		issue.u          = u_s1;
		issue.v          = v_s1;
		issue.fmt        = fmt_s1;
		issue.pair_last  = !two_px || phase_q;
		issue.frame_last = (!two_px || phase_q) && fe_s1;
	end

endmodule

`default_nettype wire

// File: design/y422rgb_matrix.sv
// Color matrix: constant multiplies in stage 2, channel sums in stage 3.
// Depends on y422rgb_pkg.
`default_nettype none

module y422rgb_matrix (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire y422rgb_pkg::issue_t issue,
	output logic                     vld_s3,
	output y422rgb_pkg::acc_t        acc_s3
);
	import y422rgb_pkg::*;

	logic              vld_s2;
	prod_t             prod_s2;
	logic [8:0]        u9, v9;
	logic signed [17:0] u_ext, v_ext, yy;

	always_comb begin
		u9    = {1'b0, issue.u} - CHROMA_OFS;
		v9    = {1'b0, issue.v} - CHROMA_OFS;
		u_ext = $signed({{9{u9[8]}}, u9});
		v_ext = $signed({{9{v9[8]}}, v9});
		yy    = $signed({2'b00, prod_s2.y, 8'h00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= issue.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2.y          <= issue.y;
		prod_s2.y_alt      <= issue.y_alt;
		prod_s2.u          <= issue.u;
		prod_s2.v          <= issue.v;
		prod_s2.fmt        <= issue.fmt;
		prod_s2.pair_last  <= issue.pair_last;
		prod_s2.frame_last <= issue.frame_last;
		prod_s2.p_rv       <= v_ext * COEF_RV;
		prod_s2.p_gu       <= u_ext * COEF_GU;
		prod_s2.p_gv       <= v_ext * COEF_GV;
		prod_s2.p_bu       <= u_ext * COEF_BU;

		acc_s3.y          <= prod_s2.y;
		acc_s3.y_alt      <= prod_s2.y_alt;
		acc_s3.u          <= prod_s2.u;
		acc_s3.v          <= prod_s2.v;
		acc_s3.fmt        <= prod_s2.fmt;
		acc_s3.pair_last  <= prod_s2.pair_last;
		acc_s3.frame_last <= prod_s2.frame_last;
		acc_s3.acc_r      <= yy + $signed(prod_s2.p_rv);
		acc_s3.acc_g      <= yy - $signed(prod_s2.p_gu) - $signed(prod_s2.p_gv);
		acc_s3.acc_b      <= yy + $signed(prod_s2.p_bu);
	end

endmodule

`default_nettype wire

// File: design/y422rgb_format.sv
// Output stage: scale and clamp the channels, pack the result register.
// Depends on y422rgb_pkg.
`default_nettype none

module y422rgb_format (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_s3,
	input  wire y422rgb_pkg::acc_t acc_s3,
	output logic                   result_valid,
	output y422rgb_pkg::result_t   result
);
	import y422rgb_pkg::*;

	// Divide by 256 rounding down, then clamp to 0..255.
	function automatic logic [7:0] clamp_chan(input logic [17:0] acc);
		logic [7:0] res;
		if (acc[17]) begin
			res = 8'h00;
		end else if (acc[16]) begin
			res = CHAN_MAX;
		end else begin
			res = acc[15:8];
		end
		return res;
	endfunction

	logic [7:0] r, g, b;
	result_t    nxt;

	always_comb begin
		r = clamp_chan(acc_s3.acc_r);
		g = clamp_chan(acc_s3.acc_g);
		b = clamp_chan(acc_s3.acc_b);
		nxt.pair_last  = acc_s3.pair_last;
		nxt.frame_last = acc_s3.frame_last;
		unique case (acc_s3.fmt)
			FMT_UYVY: begin
				nxt.out_a = acc_s3.u; nxt.out_b = acc_s3.y;
				nxt.out_c = acc_s3.v; nxt.out_d = acc_s3.y_alt;
				nxt.byte_count = CNT_FULL;
			end
			FMT_LUMA: begin
				nxt.out_a = acc_s3.y; nxt.out_b = 8'h00;
				nxt.out_c = 8'h00;    nxt.out_d = 8'h00;
				nxt.byte_count = CNT_LUMA;
			end
			FMT_RGB: begin
				nxt.out_a = r; nxt.out_b = g; nxt.out_c = b; nxt.out_d = 8'h00;
				nxt.byte_count = CNT_RGB;
			end
			FMT_BGR: begin
				nxt.out_a = b; nxt.out_b = g; nxt.out_c = r; nxt.out_d = 8'h00;
				nxt.byte_count = CNT_RGB;
			end
			FMT_BGRA: begin
				nxt.out_a = b; nxt.out_b = g; nxt.out_c = r; nxt.out_d = ALPHA_OPAQUE;
				nxt.byte_count = CNT_FULL;
			end
			default: begin
				nxt.out_a = r; nxt.out_b = g; nxt.out_c = b; nxt.out_d = ALPHA_OPAQUE;
				nxt.byte_count = CNT_FULL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		result <= nxt;
	end

endmodule

`default_nettype wire

// File: design/packed_yuv422_to_rgb.sv
// An accepted transaction passes stage 1, stages 2 and 3 and the result register
// before its first result strobe. UYVY output takes one transaction per cycle. In the
// pixel formats the two pixels share the single result port, one pixel per cycle.
// The result side cannot stall, so busy only covers the second pixel of a pair.
// Reset clears all valid bits and sets source order UYVY and target format RGBA.
// Depends on y422rgb_pkg and the unpack, matrix and format modules.
`default_nettype none

module packed_yuv422_to_rgb (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire y422rgb_pkg::mpix_t                     mpix,
	output logic                                        result_valid,
	output y422rgb_pkg::result_t                        result,
	input  wire logic                                   cfg_we,
	input  wire logic [y422rgb_pkg::CfgIndexW-1:0]      cfg_index,
	input  wire logic [y422rgb_pkg::CfgDataW-1:0]       cfg_wdata
);
	import y422rgb_pkg::*;

	// Configuration registers. The user must write them only while the pipeline is
	// empty (the block does not enforce it); stage 1 latches the format with each transaction anyway.
	logic [1:0] source_order_q;
	logic [2:0] target_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_order_q  <= SRC_UYVY;
			target_format_q <= FMT_RGBA;
		end else if (cfg_we) begin
			if (cfg_index == REG_SOURCE_ORDER) begin
				source_order_q <= cfg_wdata[1:0];
			end else if (cfg_index == REG_TARGET_FORMAT) begin
				target_format_q <= cfg_wdata;
			end
		end
	end

	// A transaction is taken whenever start is high and the input stage is free.
	logic   accept;
	issue_t issue;
	logic   vld_s3;
	acc_t   acc_s3;

	assign accept = start && !busy;

	// Stage 1: reorder the macropixel to U, Y0, V, Y1 and register it. For pixel
	// formats the stage sends Y0 and then Y1 down the pipeline, as phase_q selects.
	y422rgb_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mpix          (mpix),
		.source_order  (source_order_q),
		.target_format (target_format_q),
		.busy          (busy),
		.issue         (issue)
	);

	// Stages 2 and 3: chroma offsets and constant multiplies, then channel sums.
	y422rgb_matrix u_matrix (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.vld_s3 (vld_s3),
		.acc_s3 (acc_s3)
	);

	// Stage 4: clamping, channel order, alpha and byte count into the result register.
	y422rgb_format u_format (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_s3       (vld_s3),
		.acc_s3       (acc_s3),
		.result_valid (result_valid),
		.result       (result)
	);

	// The input stage holds off for exactly one cycle per pixel pair.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// Every accepted transaction produces a result after stage 1, stages 2 and 3 and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##3 result_valid)
		else $error("accepted transaction produced no result at the expected cycle");

	// The first pixel of a pair is always followed by the second one.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.pair_last) |=> (result_valid && result.pair_last))
		else $error("second pixel of a pair missing");

endmodule

`default_nettype wire

// File: sim/tb_packed_yuv422_to_rgb.sv
// Self-checking testbench for packed_yuv422_to_rgb: directed macropixels, then random
// ones, each checked against a table entry or a predictor that runs in step with the stimulus.
// Depends on y422rgb_pkg and the RTL of the block; reads no files.

module tb_packed_yuv422_to_rgb;

	import y422rgb_pkg::*;

	// Codes that the package leaves unnamed: the spare register indexes, the
	// undefined source order and the two undefined target formats.
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;
	localparam logic [1:0] SRC_UNDEF   = 2'd3;
	localparam logic [2:0] FMT_ALIAS_6 = 3'd6;
	localparam logic [2:0] FMT_ALIAS_7 = 3'd7;

	// Color matrix of the predictor, kept apart from the package on purpose.
	localparam int K_RV = 359;
	localparam int K_GU = 88;
	localparam int K_GV = 183;
	localparam int K_BU = 454;
	localparam int K_CHROMA_MID = 128;

	// Drain time before a register write: enough to let the second pixel of a
	// pair leave the block.
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 300000;
	localparam int DIR_ROWS     = 21;
	localparam int RAND_PHASES  = 32;

	// One row of the directed table. When typed is set, the expected results
	// are taken from e0/e1 instead of the predictor; e1 is unused for UYVY.
	typedef struct {
		bit         wr;
		logic [2:0] src_w;
		logic [2:0] fmt_w;
		mpix_t      px;
		bit         typed;
		result_t    e0;
		result_t    e1;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	mpix_t      mpix;
	logic       result_valid;
	result_t    result;
	logic       cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0]  cfg_wdata;

	// Shadow copies of the two configuration registers.
	logic [1:0] src_cur;
	logic [2:0] fmt_cur;

	// Results owed by the block, oldest first.
	result_t    owed_pixels[$];
	result_t    mon_want;

	dir_row_t   dir_tab[DIR_ROWS];
	bit         no_idle;
	int         err_cnt;
	int         results_checked;
	int         mpix_sent;
	int         settings_used;
	int         cycle_cnt;

	packed_yuv422_to_rgb dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mpix         (mpix),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Watchdog: a run that hangs on a handshake or loses a result ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles, %0d results still owed",
				cycle_cnt, owed_pixels.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic result_t mk_res(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d, input logic [2:0] cnt,
		input logic pl, input logic fl);
		result_t r;
		r.out_a      = a;
		r.out_b      = b;
		r.out_c      = c;
		r.out_d      = d;
		r.byte_count = cnt;
		r.pair_last  = pl;
		r.frame_last = fl;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input bit wr, input logic [2:0] src_w,
		input logic [2:0] fmt_w, input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d, input logic fe, input bit typed,
		input result_t e0, input result_t e1);
		dir_row_t row;
		row.wr              = wr;
		row.src_w           = src_w;
		row.fmt_w           = fmt_w;
		row.px.byte_a       = a;
		row.px.byte_b       = b;
		row.px.byte_c       = c;
		row.px.byte_d       = d;
		row.px.frame_end    = fe;
		row.typed           = typed;
		row.e0              = e0;
		row.e1              = e1;
		return row;
	endfunction

	// Scale a channel sum by 1/256 and clamp it to 0..255. Negative sums
	// are clamped before the shift, so rounding direction does not matter.
	function automatic logic [7:0] clamp_chan(input int acc);
		if (acc < 0)
			return 8'd0;
		acc = acc / 256;
		if (acc > 255)
			return 8'd255;
		return acc[7:0];
	endfunction

	// Work out the results of one macropixel under the current settings
	// and append them to the list of owed results.
	function automatic void convert_mpix(input mpix_t px);
		logic [7:0] ys[2];
		logic [7:0] cu;
		logic [7:0] cv;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [2:0] f;
		logic       pl;
		logic       fl;
		int         u;
		int         v;
		int         yy;
		case (src_cur)
			SRC_YUYV: begin
				ys[0] = px.byte_a; cu = px.byte_b; ys[1] = px.byte_c; cv = px.byte_d;
			end
			SRC_YVYU: begin
				ys[0] = px.byte_a; cv = px.byte_b; ys[1] = px.byte_c; cu = px.byte_d;
			end
			default: begin
				// UYVY, and the undefined order that falls back to it.
				cu = px.byte_a; ys[0] = px.byte_b; cv = px.byte_c; ys[1] = px.byte_d;
			end
		endcase
		if (fmt_cur == FMT_UYVY) begin
			owed_pixels.push_back(mk_res(cu, ys[0], cv, ys[1], CNT_FULL, 1'b1,
				px.frame_end));
			return;
		end
		f = (fmt_cur > FMT_BGRA) ? FMT_RGBA : fmt_cur;
		u = int'(cu) - K_CHROMA_MID;
		v = int'(cv) - K_CHROMA_MID;
		for (int k = 0; k < 2; k++) begin
			pl = (k == 1);
			fl = (k == 1) ? px.frame_end : 1'b0;
			yy = int'(ys[k]) * 256;
			r  = clamp_chan(yy + K_RV * v);
			g  = clamp_chan(yy - K_GU * u - K_GV * v);
			b  = clamp_chan(yy + K_BU * u);
			case (f)
				FMT_LUMA: owed_pixels.push_back(mk_res(ys[k], 8'd0, 8'd0, 8'd0, CNT_LUMA, pl, fl));
				FMT_RGB:  owed_pixels.push_back(mk_res(r, g, b, 8'd0, CNT_RGB, pl, fl));
				FMT_BGR:  owed_pixels.push_back(mk_res(b, g, r, 8'd0, CNT_RGB, pl, fl));
				FMT_RGBA: owed_pixels.push_back(mk_res(r, g, b, ALPHA_OPAQUE, CNT_FULL, pl, fl));
				default:  owed_pixels.push_back(mk_res(b, g, r, ALPHA_OPAQUE, CNT_FULL, pl, fl));
			endcase
		end
	endfunction

	// Byte values lean toward the ends of the range and toward the chroma
	// midpoint, where saturation and neutral gray are decided.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(120, 136));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic mpix_t random_mpix();
		mpix_t px;
		px.byte_a    = pick_byte();
		px.byte_b    = pick_byte();
		px.byte_c    = pick_byte();
		px.byte_d    = pick_byte();
		px.frame_end = ($urandom_range(0, 5) == 0);
		return px;
	endfunction

	// Idle gaps before a transaction: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			err_cnt++;
		end
	endtask

	// Every strobed result is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (owed_pixels.size() == 0) begin
				$error("Result with none owed: %p", result);
				err_cnt++;
			end else begin
				mon_want = owed_pixels.pop_front();
				check_field("out_a", mon_want.out_a, result.out_a);
				check_field("out_b", mon_want.out_b, result.out_b);
				check_field("out_c", mon_want.out_c, result.out_c);
				check_field("out_d", mon_want.out_d, result.out_d);
				check_field("byte_count", 8'(mon_want.byte_count), 8'(result.byte_count));
				check_field("pair_last", 8'(mon_want.pair_last), 8'(result.pair_last));
				check_field("frame_last", 8'(mon_want.frame_last), 8'(result.frame_last));
				results_checked++;
			end
		end
	end

	// Drop start, wait for every owed result, then let the block drain.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (owed_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [2:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_SOURCE_ORDER)
			src_cur = data[1:0];
		else if (idx == REG_TARGET_FORMAT)
			fmt_cur = data;
	endtask

	// A new setting is applied only once the block is idle. A write to a
	// spare index goes first each time; the block must ignore it.
	task automatic apply_setting(input logic [2:0] src_w, input logic [2:0] fmt_w);
		settle();
		write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
			3'($urandom_range(0, 7)));
		write_reg(REG_SOURCE_ORDER, src_w);
		write_reg(REG_TARGET_FORMAT, fmt_w);
		settings_used++;
	endtask

	// Present one macropixel after a random gap and hold it until the block
	// takes the transaction; its expected results are queued at that edge.
	task automatic send_mpix(input mpix_t px, input bit typed, input result_t e0,
		input result_t e1);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			mpix  <= random_mpix();
		end
		@(negedge clk);
		start <= 1'b1;
		mpix  <= px;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (typed) begin
			owed_pixels.push_back(e0);
			if (fmt_cur != FMT_UYVY)
				owed_pixels.push_back(e1);
		end else begin
			convert_mpix(px);
		end
		mpix_sent++;
	endtask

	initial begin
		int         n_items;
		int         p;
		logic [2:0] sw;
		logic [2:0] fw;
		result_t    none;

		none = '0;
		arst_n    = 1'b0;
		start     = 1'b0;
		mpix      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		src_cur   = SRC_UYVY;
		fmt_cur   = FMT_RGBA;
		no_idle   = 1'b0;
		err_cnt   = 0;
		results_checked = 0;
		mpix_sent       = 0;
		settings_used   = 0;
		cycle_cnt       = 0;

		// Directed table. The first two rows run on the reset settings.
		// Typed rows hold results that follow directly from the inputs:
		// reordering, luma pass-through, neutral gray and the clamped extremes.
		dir_tab[0]  = mk_row(0, {1'b0, SRC_UYVY}, FMT_RGBA, 8'h80, 8'h00, 8'h80, 8'hFF, 0, 1,
			mk_res(8'h00, 8'h00, 8'h00, 8'hFF, CNT_FULL, 0, 0),
			mk_res(8'hFF, 8'hFF, 8'hFF, 8'hFF, CNT_FULL, 1, 0));
		dir_tab[1]  = mk_row(0, {1'b0, SRC_UYVY}, FMT_RGBA, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 0,
			none, none);
		dir_tab[2]  = mk_row(1, {1'b0, SRC_UYVY}, FMT_UYVY, 8'h11, 8'h22, 8'h33, 8'h44, 1, 1,
			mk_res(8'h11, 8'h22, 8'h33, 8'h44, CNT_FULL, 1, 1), none);
		dir_tab[3]  = mk_row(1, {1'b0, SRC_YUYV}, FMT_UYVY, 8'h11, 8'h22, 8'h33, 8'h44, 0, 1,
			mk_res(8'h22, 8'h11, 8'h44, 8'h33, CNT_FULL, 1, 0), none);
		dir_tab[4]  = mk_row(1, {1'b0, SRC_YVYU}, FMT_UYVY, 8'h11, 8'h22, 8'h33, 8'h44, 0, 1,
			mk_res(8'h44, 8'h11, 8'h22, 8'h33, CNT_FULL, 1, 0), none);
		// The undefined source order behaves as UYVY.
		dir_tab[5]  = mk_row(1, {1'b0, SRC_UNDEF}, FMT_UYVY, 8'hFF, 8'h00, 8'hFF, 8'h00, 1, 1,
			mk_res(8'hFF, 8'h00, 8'hFF, 8'h00, CNT_FULL, 1, 1), none);
		// Only the low two bits of the write data reach the source order.
		dir_tab[6]  = mk_row(1, {1'b1, SRC_UYVY}, FMT_UYVY, 8'h00, 8'hFF, 8'h00, 8'hFF, 0, 1,
			mk_res(8'h00, 8'hFF, 8'h00, 8'hFF, CNT_FULL, 1, 0), none);
		dir_tab[7]  = mk_row(1, {1'b0, SRC_UYVY}, FMT_LUMA, 8'h80, 8'h00, 8'h80, 8'hFF, 1, 1,
			mk_res(8'h00, 8'h00, 8'h00, 8'h00, CNT_LUMA, 0, 0),
			mk_res(8'hFF, 8'h00, 8'h00, 8'h00, CNT_LUMA, 1, 1));
		dir_tab[8]  = mk_row(1, {1'b0, SRC_YUYV}, FMT_LUMA, 8'hFF, 8'h00, 8'h07, 8'h00, 0, 1,
			mk_res(8'hFF, 8'h00, 8'h00, 8'h00, CNT_LUMA, 0, 0),
			mk_res(8'h07, 8'h00, 8'h00, 8'h00, CNT_LUMA, 1, 0));
		dir_tab[9]  = mk_row(1, {1'b0, SRC_UYVY}, FMT_RGB, 8'h80, 8'hFF, 8'h80, 8'h00, 0, 1,
			mk_res(8'hFF, 8'hFF, 8'hFF, 8'h00, CNT_RGB, 0, 0),
			mk_res(8'h00, 8'h00, 8'h00, 8'h00, CNT_RGB, 1, 0));
		dir_tab[10] = mk_row(0, {1'b0, SRC_UYVY}, FMT_RGB, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1, 0,
			none, none);
		// Lowest chroma at black: red and blue clamp to zero, green is 135.
		dir_tab[11] = mk_row(1, {1'b0, SRC_UYVY}, FMT_BGR, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1,
			mk_res(8'h00, 8'd135, 8'h00, 8'h00, CNT_RGB, 0, 0),
			mk_res(8'h00, 8'd135, 8'h00, 8'h00, CNT_RGB, 1, 1));
		dir_tab[12] = mk_row(1, {1'b0, SRC_YUYV}, FMT_BGR, 8'h5A, 8'h3C, 8'hC8, 8'hF0, 0, 0,
			none, none);
		dir_tab[13] = mk_row(1, {1'b0, SRC_YVYU}, FMT_RGBA, 8'h10, 8'hE0, 8'hEB, 8'h20, 1, 0,
			none, none);
		dir_tab[14] = mk_row(1, {1'b0, SRC_UYVY}, FMT_BGRA, 8'h80, 8'hC8, 8'h80, 8'h32, 0, 1,
			mk_res(8'hC8, 8'hC8, 8'hC8, 8'hFF, CNT_FULL, 0, 0),
			mk_res(8'h32, 8'h32, 8'h32, 8'hFF, CNT_FULL, 1, 0));
		dir_tab[15] = mk_row(0, {1'b0, SRC_UYVY}, FMT_BGRA, 8'h00, 8'hFF, 8'hFF, 8'h00, 1, 0,
			none, none);
		// Both undefined target formats fall back to RGBA.
		dir_tab[16] = mk_row(1, {1'b0, SRC_UYVY}, FMT_ALIAS_6, 8'h80, 8'h40, 8'h80, 8'hC0, 1, 1,
			mk_res(8'h40, 8'h40, 8'h40, 8'hFF, CNT_FULL, 0, 0),
			mk_res(8'hC0, 8'hC0, 8'hC0, 8'hFF, CNT_FULL, 1, 1));
		dir_tab[17] = mk_row(1, {1'b0, SRC_YUYV}, FMT_ALIAS_7, 8'h9B, 8'h17, 8'h64, 8'hE2, 0, 0,
			none, none);
		dir_tab[18] = mk_row(1, {1'b0, SRC_YVYU}, FMT_ALIAS_7, 8'hFF, 8'h00, 8'h00, 8'hFF, 1, 0,
			none, none);
		dir_tab[19] = mk_row(1, {1'b0, SRC_YUYV}, FMT_RGB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0,
			none, none);
		dir_tab[20] = mk_row(1, {1'b0, SRC_UYVY}, FMT_UYVY, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1,
			mk_res(8'h00, 8'h00, 8'h00, 8'h00, CNT_FULL, 1, 0), none);

		// Reset is held from time zero and released on a falling edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].wr)
				apply_setting(dir_tab[i].src_w, dir_tab[i].fmt_w);
			send_mpix(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].e0, dir_tab[i].e1);
		end

		// Random part: every source order against every target format, the
		// undefined codes included, visited in a scrambled order. Bit 2 of the
		// source-order write is set now and then; the block must drop it.
		// About one phase in four runs without any idle cycles.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			p  = (ph * 13) % RAND_PHASES;
			sw = {1'($urandom_range(0, 3) == 0), 2'(p % 4)};
			fw = 3'(p / 4);
			apply_setting(sw, fw);
			no_idle = ($urandom_range(0, 3) == 0);
			n_items = $urandom_range(14, 20);
			for (int j = 0; j < n_items; j++)
				send_mpix(random_mpix(), 0, none, none);
		end
		no_idle = 1'b0;

		settle();
		$display("Sent %0d macropixel transactions (%0d directed) over %0d settings;",
			mpix_sent, DIR_ROWS, settings_used);
		$display("checked %0d results, %0d mismatches.", results_checked, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
